// ----- rtl/pls_pkg.sv -----
// Shared constants and types for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int MODE_W  = 2;
   localparam int VALUE_W = 8;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   // Broadcast command to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_cmd_type;

endpackage

// ----- rtl/pls_ifs.sv -----
// Valid/ready channel interfaces for operation items and result items.
`timescale 1ns / 1ps

interface pls_req_if;
   logic                            valid;
   logic                            ready;
   logic [pls_pkg::MODE_W-1:0]      mode;
   logic [pls_pkg::VALUE_W-1:0]     value;
   logic [pls_pkg::POS_W-1:0]       position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface pls_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pls_pkg::VALUE_W-1:0]     popped_value;
   logic [pls_pkg::STAT_W-1:0]      status;
   logic [pls_pkg::COUNT_W-1:0]     count_after;

   modport source (output valid, output popped_value, output status, output count_after,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input count_after,
                   output ready);
endinterface

// ----- rtl/pls_cell.sv -----
// One storage cell of the list chain: loads, shifts from a neighbor or holds.
`timescale 1ns / 1ps

module pls_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  pls_pkg::cell_cmd_type          cmd,
   input  logic [IDX_W-1:0]               slot,
   input  logic [pls_pkg::VALUE_W-1:0]    value,
   input  logic [pls_pkg::VALUE_W-1:0]    left_data,
   input  logic [pls_pkg::VALUE_W-1:0]    right_data,
   output logic [pls_pkg::VALUE_W-1:0]    data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [pls_pkg::VALUE_W-1:0] data_ff;
   logic [pls_pkg::VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.insert) begin
         if (MY_IDX == slot) begin
            data_in = value;
         end else if (MY_IDX > slot) begin
            // cells past the insert point move one step toward the back
            data_in = left_data;
         end
      end else if (cmd.pop) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/positional_list_store.sv -----
// Positional list store: a row of DEPTH byte cells with front/back/positional insert and pop.
// Result items are registered and valid in the cycle after the operation item is accepted.
// One item per cycle while no result waits; all cells shift in the same cycle as the update.
// A result that waits holds off the next item; ready follows the result side.
// Reset (synchronous): count goes to zero and the result register empties;
// cell contents are left undefined until written.
`timescale 1ns / 1ps

module positional_list_store #(
   parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pls_req_if.sink     req_chan,
   pls_rsp_if.source   rsp_chan
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [pls_pkg::VALUE_W-1:0]    popped_ff;
   logic [pls_pkg::VALUE_W-1:0]    popped_in;
   logic [pls_pkg::STAT_W-1:0]     status_ff;
   logic [pls_pkg::STAT_W-1:0]     status_in;
   logic [pls_pkg::COUNT_W-1:0]    count_out_ff;
   logic [pls_pkg::COUNT_W-1:0]    count_out_in;

   logic                           accept;
   logic                           full;
   logic                           empty;
   logic [CMP_W-1:0]               pos_ext;
   logic [CMP_W-1:0]               count_ext;
   logic [IDX_W-1:0]               slot;
   pls_pkg::cell_cmd_type          cmd;
   logic [pls_pkg::VALUE_W-1:0]    cell_data [DEPTH];

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pos_ext   = CMP_W'(req_chan.position);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      cmd       = '0;
      slot      = '0;
      count_in  = count_ff;
      status_in = pls_pkg::ST_OK;
      popped_in = '0;
      if (req_chan.mode == pls_pkg::MODE_POP) begin
         if (empty) begin
            status_in = pls_pkg::ST_EMPTY;
         end else begin
            cmd.pop   = accept;
            popped_in = cell_data[0];
            count_in  = count_ff - CNT_W'(1);
         end
      end else if (full) begin
         status_in = pls_pkg::ST_FULL;
      end else begin
         case (req_chan.mode)
            pls_pkg::MODE_APPEND: slot = count_ff[IDX_W-1:0];
            pls_pkg::MODE_PUSH:   slot = '0;
            default:              slot = pos_ext[IDX_W-1:0];
         endcase
         if (req_chan.mode == pls_pkg::MODE_INSERT && pos_ext > count_ext) begin
            status_in = pls_pkg::ST_BADPOS;
         end else begin
            cmd.insert = accept;
            count_in   = count_ff + CNT_W'(1);
         end
      end
      count_out_in = pls_pkg::COUNT_W'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pls_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .slot       (slot),
         .value      (req_chan.value),
         .left_data  ((i == 0) ? req_chan.value : cell_data[(i == 0) ? 0 : i - 1]),
         .right_data ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i == DEPTH - 1) ? i : i + 1]),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         popped_ff    <= popped_in;
         status_ff    <= status_in;
         count_out_ff <= count_out_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.count_after  = count_out_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.mode == pls_pkg::MODE_POP && !empty
      |=> count_ff == $past(count_ff) - CNT_W'(1) && status_ff == pls_pkg::ST_OK)
      else $error("pop on non-empty list did not shrink count");

   a_append_inc: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.mode == pls_pkg::MODE_APPEND && !full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == pls_pkg::ST_FULL
      |-> count_out_ff == pls_pkg::COUNT_W'(DEPTH) && popped_ff == '0)
      else $error("full status with wrong count or popped value");
`endif

endmodule

// ----- bench/positional_list_store_check.sv -----
// Result checker for the positional list store: tracks the list and compares every result item.
`timescale 1ns / 1ps

module positional_list_store_check #(
   parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   pls_req_if    req_chan,
   pls_rsp_if    rsp_chan,
   output int    error_count,
   output int    pending
);

   typedef struct packed {
      logic [pls_pkg::VALUE_W-1:0] popped_value;
      logic [pls_pkg::STAT_W-1:0]  status;
      logic [pls_pkg::COUNT_W-1:0] count_after;
   } list_result_type;

   logic [pls_pkg::VALUE_W-1:0] shadow_chars [DEPTH];
   int                          shadow_len = 0;
   list_result_type             pending_results [$];

   initial begin
      error_count = 0;
      pending     = 0;
   end

   // Applies one operation to the shadow list and returns the result it should produce.
   function automatic list_result_type apply_list_op(
         input logic [pls_pkg::MODE_W-1:0]  mode,
         input logic [pls_pkg::VALUE_W-1:0] ch,
         input logic [pls_pkg::POS_W-1:0]   slot);
      list_result_type res;
      int              at;
      res = '0;
      at  = -1;
      if (mode == pls_pkg::MODE_POP) begin
         if (shadow_len == 0) begin
            res.status = pls_pkg::ST_EMPTY;
         end else begin
            res.popped_value = shadow_chars[0];
            for (int i = 0; i < shadow_len - 1; i++) shadow_chars[i] = shadow_chars[i + 1];
            shadow_len--;
         end
      end else if (shadow_len >= DEPTH) begin
         // full is reported ahead of a bad position
         res.status = pls_pkg::ST_FULL;
      end else if (mode == pls_pkg::MODE_APPEND) begin
         at = shadow_len;
      end else if (mode == pls_pkg::MODE_PUSH) begin
         at = 0;
      end else if (int'(slot) > shadow_len) begin
         res.status = pls_pkg::ST_BADPOS;
      end else begin
         at = int'(slot);
      end
      if (at >= 0) begin
         for (int i = shadow_len; i > at; i--) shadow_chars[i] = shadow_chars[i - 1];
         shadow_chars[at] = ch;
         shadow_len++;
      end
      res.count_after = pls_pkg::COUNT_W'(shadow_len);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t: list result mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         shadow_len = 0;
         pending_results.delete();
      end else begin
         // a result never belongs to the item accepted in the same cycle
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected item popped=%0d status=%0d count=%0d",
                                         rsp_chan.popped_value, rsp_chan.status,
                                         rsp_chan.count_after));
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.popped_value !== want.popped_value)
                  report_mismatch($sformatf("popped_value got %0d expected %0d",
                                            rsp_chan.popped_value, want.popped_value));
               if (rsp_chan.status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_chan.status, want.status));
               if (rsp_chan.count_after !== want.count_after)
                  report_mismatch($sformatf("count_after got %0d expected %0d",
                                            rsp_chan.count_after, want.count_after));
            end
         end
         if (req_chan.valid && req_chan.ready)
            pending_results.push_back(apply_list_op(req_chan.mode, req_chan.value,
                                                    req_chan.position));
      end
      pending <= pending_results.size();
   end

endmodule

// ----- bench/positional_list_store_tb.sv -----
// Top of the positional list store testbench: clock, reset, operation stimulus and verdict.
`timescale 1ns / 1ps

module positional_list_store_tb;

   localparam int LIST_DEPTH  = pls_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_OPS  = 1400;
   localparam int PHASE_OPS   = 50;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   fill_level  = 0;
   int   stall_left  = 0;
   int   idle_cycles = 0;
   int   error_count;
   int   pending;

   pls_req_if req_chan ();
   pls_rsp_if rsp_chan ();

   positional_list_store #(.DEPTH(LIST_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   positional_list_store_check #(.DEPTH(LIST_DEPTH)) result_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .error_count (error_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result-side back-pressure: mostly short stalls, now and then a long one.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
         rsp_chan.ready <= 1'b0;
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(7, 39);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic issue_op(input logic [pls_pkg::MODE_W-1:0]  mode,
                           input logic [pls_pkg::VALUE_W-1:0] value,
                           input logic [pls_pkg::POS_W-1:0]   position);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.value    <= value;
      req_chan.position <= position;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // rough occupancy, only used to aim insert positions
      if (mode == pls_pkg::MODE_POP) begin
         if (fill_level > 0) fill_level--;
      end else if (fill_level < LIST_DEPTH &&
                   !(mode == pls_pkg::MODE_INSERT && position > fill_level)) begin
         fill_level++;
      end
   endtask

   task automatic random_op(input int insert_pct);
      logic [pls_pkg::MODE_W-1:0] mode;
      logic [pls_pkg::POS_W-1:0]  position;
      int                         r;
      if ($urandom_range(0, 99) < insert_pct) begin
         r = $urandom_range(0, 3);
         mode = (r == 0) ? pls_pkg::MODE_APPEND :
                (r == 1) ? pls_pkg::MODE_PUSH : pls_pkg::MODE_INSERT;
      end else begin
         mode = pls_pkg::MODE_POP;
      end
      r = $urandom_range(0, 99);
      if (r < 85)      position = pls_pkg::POS_W'($urandom_range(0, fill_level));
      else if (r < 95) position = pls_pkg::POS_W'($urandom_range(fill_level + 1, 31));
      else             position = pls_pkg::POS_W'($urandom_range(0, 31));
      issue_op(mode, pls_pkg::VALUE_W'($urandom_range(0, 255)), position);
   endtask

   initial begin
      int insert_pct;
      insert_pct        = 50;
      req_chan.valid    = 1'b0;
      req_chan.mode     = pls_pkg::MODE_APPEND;
      req_chan.value    = '0;
      req_chan.position = '0;
      rsp_chan.ready    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list corner cases, each mode, then fill to the top
      issue_op(pls_pkg::MODE_POP, 8'hFF, 5'd31);
      issue_op(pls_pkg::MODE_INSERT, 8'h11, 5'd1);
      issue_op(pls_pkg::MODE_INSERT, 8'h00, 5'd0);
      issue_op(pls_pkg::MODE_APPEND, 8'hFF, 5'd0);
      issue_op(pls_pkg::MODE_PUSH, 8'hA5, 5'd31);
      issue_op(pls_pkg::MODE_INSERT, 8'h5A, 5'd3);
      issue_op(pls_pkg::MODE_INSERT, 8'h3C, 5'd1);
      issue_op(pls_pkg::MODE_POP, 8'h00, 5'd0);
      for (int k = 0; k < 12; k++)
         issue_op((k % 3 == 0) ? pls_pkg::MODE_APPEND :
                  (k % 3 == 1) ? pls_pkg::MODE_PUSH : pls_pkg::MODE_INSERT,
                  pls_pkg::VALUE_W'(k * 17 + 1), pls_pkg::POS_W'(fill_level / 2));
      // list is full: every insert kind is refused, full wins over a bad position
      issue_op(pls_pkg::MODE_APPEND, 8'h77, 5'd0);
      issue_op(pls_pkg::MODE_PUSH, 8'h88, 5'd0);
      issue_op(pls_pkg::MODE_INSERT, 8'h99, 5'd0);
      issue_op(pls_pkg::MODE_INSERT, 8'h99, 5'd31);

      // random phases each lean toward filling or draining the list, chosen at random
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % PHASE_OPS == 0) begin
            insert_pct = $urandom_range(0, 1) ? 75 : 30;
            quiet      = ($urandom_range(0, 3) == 0);
         end
         random_op(insert_pct);
      end
      quiet = 1'b0;
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
